// File: design/assert_macros.svh
// assertion macros for the sync level lock stack
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define SLC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("slc assertion failed");

// condition must never be seen outside reset
`define SLC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("slc forbidden condition seen");

`endif

// File: design/slc_pkg.sv
// shared types and constants for the sync level lock stack
// no dependencies; used by slc_cell, sync_level_lock_stack and the testbench
package slc_pkg;

  localparam int DEF_STACK_DEPTH = 16;
  localparam int DEF_ID_BITS     = 8;
  localparam int LEVEL_W         = 4;
  localparam int STATUS_W        = 3;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TIMEOUT   = 3'd1,
    ST_NOT_LOCK  = 3'd2,
    ST_LEVEL_LOW = 3'd3,
    ST_NONE_HELD = 3'd4,
    ST_NOT_TOP   = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
    logic shift;
  } cell_ctl_t;

endpackage

// File: design/slc_cell.sv
// one stack entry: lock id and level, shifts on push and pop, ripples the match flag
// depends on slc_pkg
module slc_cell import slc_pkg::*; #(
  parameter int ID_BITS = DEF_ID_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctl_t          ctl_i,
  input  logic               in_use_i,
  input  logic [ID_BITS-1:0] key_i,
  input  logic [ID_BITS-1:0] up_id_i,
  input  logic [LEVEL_W-1:0] up_level_i,
  input  logic [ID_BITS-1:0] dn_id_i,
  input  logic [LEVEL_W-1:0] dn_level_i,
  input  logic               flag_i,
  output logic [ID_BITS-1:0] id_o,
  output logic [LEVEL_W-1:0] level_o,
  output logic               flag_o
);

  logic [ID_BITS-1:0] id_q;
  logic [LEVEL_W-1:0] level_q;
  logic               flag_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      id_q    <= up_id_i;
      level_q <= up_level_i;
    end else if (ctl_i.pop) begin
      id_q    <= dn_id_i;
      level_q <= dn_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (ctl_i.clr) begin
      flag_q <= 1'b0;
    end else if (ctl_i.shift) begin
      flag_q <= flag_i;
    end
  end

  assign id_o    = id_q;
  assign level_o = level_q;
  assign flag_o  = flag_q | (in_use_i && (id_q == key_i));

endmodule

// File: design/sync_level_lock_stack.sv
// top level of the sync level lock stack: control, chain of entry cells, result beat
// depends on slc_pkg, slc_cell and assert_macros.svh
//
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+-------------------------------------------
// command   | in        | start_i & !busy_o     | cmd, lock_id, is_lock, lock_level, granted
// result    | out       | done_o (one cycle)    | status, already_held, release_lock,
//           |           |                       | current_level, held_count
//
// a command scans the chain: the held-match flag ripples one cell per cycle down the chain,
// and the last scan cycle decides and, if the command goes through, pushes or pops the whole chain at once
// the result beat follows in the next cycle with busy_o already low, so a new command can
// start as the beat is shown; no command is taken while busy_o is high
// reset empties the stack at once; entry contents need no clearing
// the receiver cannot stall: each result beat stands for exactly one cycle
`include "assert_macros.svh"

module sync_level_lock_stack import slc_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               cmd_i,
  input  logic [ID_BITS-1:0]                 lock_id_i,
  input  logic                               is_lock_i,
  input  logic [LEVEL_W-1:0]                 lock_level_i,
  input  logic                               granted_i,
  output logic                               done_o,
  output logic [STATUS_W-1:0]                status_o,
  output logic                               already_held_o,
  output logic                               release_lock_o,
  output logic [LEVEL_W-1:0]                 current_level_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   held_count_o
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int SCAN_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(STACK_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

  state_e              state_q, state_d;
  logic [SCAN_W-1:0]   scan_q, scan_d;
  logic [CNT_W-1:0]    depth_q, depth_d;
  logic [LEVEL_W-1:0]  top_q, top_d;
  logic                done_q, done_d;

  logic                cmd_q;
  logic [ID_BITS-1:0]  key_q;
  logic                is_lock_q;
  logic [LEVEL_W-1:0]  level_q;
  logic                granted_q;

  status_e             status_q, status_d;
  logic                already_q, already_d;
  logic                rel_q, rel_d;

  cell_ctl_t           ctl;
  logic                accept;

  logic [ID_BITS-1:0]  id_w    [STACK_DEPTH];
  logic [LEVEL_W-1:0]  lvl_w   [STACK_DEPTH];
  logic                flag_w  [STACK_DEPTH];
  logic [LEVEL_W-1:0]  next_lvl;

  assign accept = start_i && (state_q == S_IDLE);

  // entry 0 is the top of the stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0] up_id;
    logic [LEVEL_W-1:0] up_lvl;
    logic [ID_BITS-1:0] dn_id;
    logic [LEVEL_W-1:0] dn_lvl;
    logic               fl_in;
    logic               in_use;

    if (i == 0) begin : g_head
      assign up_id  = key_q;
      assign up_lvl = level_q;
      assign fl_in  = 1'b0;
    end else begin : g_body
      assign up_id  = id_w[i-1];
      assign up_lvl = lvl_w[i-1];
      assign fl_in  = flag_w[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_tail
      assign dn_id  = '0;
      assign dn_lvl = '0;
    end else begin : g_mid
      assign dn_id  = id_w[i+1];
      assign dn_lvl = lvl_w[i+1];
    end

    assign in_use = (CNT_W'(i) < depth_q);

    slc_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .in_use_i   (in_use),
      .key_i      (key_q),
      .up_id_i    (up_id),
      .up_level_i (up_lvl),
      .dn_id_i    (dn_id),
      .dn_level_i (dn_lvl),
      .flag_i     (fl_in),
      .id_o       (id_w[i]),
      .level_o    (lvl_w[i]),
      .flag_o     (flag_w[i])
    );
  end

  if (STACK_DEPTH > 1) begin : g_next
    assign next_lvl = lvl_w[1];
  end else begin : g_no_next
    assign next_lvl = '0;
  end

  always_comb begin
    state_d   = state_q;
    scan_d    = scan_q;
    depth_d   = depth_q;
    top_d     = top_q;
    done_d    = 1'b0;
    status_d  = status_q;
    already_d = already_q;
    rel_d     = rel_q;
    ctl       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_SCAN;
          scan_d  = '0;
          ctl.clr = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_q == SCAN_LAST) begin
          state_d   = S_IDLE;
          done_d    = 1'b1;
          status_d  = ST_OK;
          already_d = 1'b0;
          rel_d     = 1'b0;
          if (!is_lock_q) begin
            status_d = ST_NOT_LOCK;
          end else if (cmd_q == CMD_ACQUIRE) begin
            if (level_q < top_q) begin
              status_d = ST_LEVEL_LOW;
            end else if (flag_w[STACK_DEPTH-1]) begin
              already_d = 1'b1;
            end else if (!granted_q) begin
              status_d = ST_TIMEOUT;
            end else if (depth_q >= CNT_FULL) begin
              status_d = ST_FULL;
              rel_d    = 1'b1;
            end else begin
              ctl.push = 1'b1;
              depth_d  = depth_q + CNT_ONE;
              top_d    = level_q;
            end
          end else begin
            if (depth_q == '0) begin
              status_d = ST_NONE_HELD;
            end else if (id_w[0] != key_q) begin
              status_d = ST_NOT_TOP;
            end else begin
              rel_d   = 1'b1;
              ctl.pop = 1'b1;
              depth_d = depth_q - CNT_ONE;
              top_d   = (depth_q == CNT_ONE) ? '0 : next_lvl;
            end
          end
        end else begin
          ctl.shift = 1'b1;
          scan_d    = scan_q + SCAN_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= '0;
      depth_q <= '0;
      top_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      depth_q <= depth_d;
      top_q   <= top_d;
      done_q  <= done_d;
    end
  end

  // command beat and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_i;
      key_q     <= lock_id_i;
      is_lock_q <= is_lock_i;
      level_q   <= lock_level_i;
      granted_q <= granted_i;
    end
    status_q  <= status_d;
    already_q <= already_d;
    rel_q     <= rel_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign already_held_o  = already_q && done_q;
  assign release_lock_o  = rel_q && done_q;
  assign current_level_o = top_q;
  assign held_count_o    = depth_q;

  `SLC_ASSERT_NEVER(a_depth_bound, clk_i, rst_ni, depth_q > CNT_FULL)
  `SLC_ASSERT(a_beat_when_idle, clk_i, rst_ni, done_q |-> (state_q == S_IDLE))
  `SLC_ASSERT(a_depth_moves_on_decide, clk_i, rst_ni, (depth_q != $past(depth_q)) |-> ($past(state_q) == S_SCAN))
  `SLC_ASSERT(a_release_in_beat, clk_i, rst_ni, release_lock_o |-> done_o)

endmodule

// File: bench/testbench.sv
// self-checking bench for sync_level_lock_stack: directed and random lock commands
// depends on slc_pkg and the sync_level_lock_stack rtl; a small ledger class predicts each beat
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import slc_pkg::*;

  localparam int DEPTH = DEF_STACK_DEPTH;
  localparam int ID_W  = DEF_ID_BITS;
  localparam int CNT_W = $clog2(DEF_STACK_DEPTH + 1);

  typedef struct {
    status_e            status;
    logic               already;
    logic               rel;
    logic [LEVEL_W-1:0] level;
    logic [CNT_W-1:0]   count;
  } outcome_t;

  class lock_stack_ledger;
    logic [ID_W-1:0]    held_ids[DEPTH];
    logic [LEVEL_W-1:0] held_lvls[DEPTH];
    int unsigned        depth;
    logic [LEVEL_W-1:0] top;
    outcome_t           due[$];
    int unsigned        errors;

    function new();
      depth  = 0;
      top    = '0;
      errors = 0;
    endfunction

    function bit is_held(logic [ID_W-1:0] id);
      for (int i = 0; i < depth; i++) begin
        if (held_ids[i] == id) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_command(logic cmd, logic [ID_W-1:0] id, logic is_lock,
                               logic [LEVEL_W-1:0] level, logic granted);
      outcome_t o;
      o.status  = ST_OK;
      o.already = 1'b0;
      o.rel     = 1'b0;
      if (!is_lock) begin
        o.status = ST_NOT_LOCK;
      end else if (cmd == CMD_ACQUIRE) begin
        if (level < top) begin
          o.status = ST_LEVEL_LOW;
        end else if (is_held(id)) begin
          o.already = 1'b1;
        end else if (!granted) begin
          o.status = ST_TIMEOUT;
        end else if (depth >= DEPTH) begin
          o.status = ST_FULL;
          o.rel    = 1'b1;
        end else begin
          held_ids[depth]  = id;
          held_lvls[depth] = level;
          depth++;
          top = level;
        end
      end else begin
        if (depth == 0) begin
          o.status = ST_NONE_HELD;
        end else if (held_ids[depth-1] != id) begin
          o.status = ST_NOT_TOP;
        end else begin
          o.rel = 1'b1;
          depth--;
          top = (depth == 0) ? '0 : held_lvls[depth-1];
        end
      end
      o.level = top;
      o.count = CNT_W'(depth);
      due.push_back(o);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] error: %s", $time, what);
    endtask

    task check_beat(logic [STATUS_W-1:0] status, logic already, logic rel,
                    logic [LEVEL_W-1:0] level, logic [CNT_W-1:0] count);
      outcome_t o;
      if (due.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      o = due.pop_front();
      if (status !== o.status)
        report($sformatf("status %0d, want %0d", status, o.status));
      if (already !== o.already)
        report($sformatf("already_held %0b, want %0b", already, o.already));
      if (rel !== o.rel)
        report($sformatf("release_lock %0b, want %0b", rel, o.rel));
      if (level !== o.level)
        report($sformatf("current_level %0d, want %0d", level, o.level));
      if (count !== o.count)
        report($sformatf("held_count %0d, want %0d", count, o.count));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               cmd_i = CMD_ACQUIRE;
  logic [ID_W-1:0]    lock_id_i = '0;
  logic               is_lock_i = 1'b0;
  logic [LEVEL_W-1:0] lock_level_i = '0;
  logic               granted_i = 1'b0;
  logic               done_o;
  logic [STATUS_W-1:0] status_o;
  logic               already_held_o;
  logic               release_lock_o;
  logic [LEVEL_W-1:0] current_level_o;
  logic [CNT_W-1:0]   held_count_o;

  lock_stack_ledger ledger = new();
  bit               no_gaps = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sync_level_lock_stack uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .lock_id_i      (lock_id_i),
    .is_lock_i      (is_lock_i),
    .lock_level_i   (lock_level_i),
    .granted_i      (granted_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .already_held_o (already_held_o),
    .release_lock_o (release_lock_o),
    .current_level_o(current_level_o),
    .held_count_o   (held_count_o)
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      ledger.check_beat(status_o, already_held_o, release_lock_o, current_level_o,
                        held_count_o);
  end

  task send(logic cmd, logic [ID_W-1:0] id, logic is_lock, logic [LEVEL_W-1:0] level,
            logic granted);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    cmd_i        <= cmd;
    lock_id_i    <= id;
    is_lock_i    <= is_lock;
    lock_level_i <= level;
    granted_i    <= granted;
    start_i      <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    ledger.note_command(cmd, id, is_lock, level, granted);
  endtask

  task drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (ledger.due.size() != 0) @(posedge clk_i);
  endtask

  // mostly well-formed acquire/release traffic built on the predicted stack
  task send_random(int acq_pct);
    int                 r;
    logic               cmd;
    logic [ID_W-1:0]    id;
    logic               is_lock;
    logic [LEVEL_W-1:0] level;
    logic               granted;
    int                 lv;
    r       = $urandom_range(0, 99);
    cmd     = CMD_ACQUIRE;
    id      = ID_W'($urandom);
    is_lock = 1'b1;
    level   = LEVEL_W'($urandom);
    granted = 1'b1;
    if (r < 5) begin
      cmd     = 1'($urandom_range(0, 1));
      is_lock = 1'($urandom_range(0, 1));
      granted = 1'($urandom_range(0, 1));
    end else if (r < 10) begin
      cmd     = 1'($urandom_range(0, 1));
      is_lock = 1'b0;
      granted = 1'($urandom_range(0, 1));
    end else if (r < acq_pct) begin
      lv = int'(ledger.top) + $urandom_range(0, 2);
      level = (lv > 15) ? 4'd15 : LEVEL_W'(lv);
      if (ledger.top > 0 && $urandom_range(0, 9) == 0)
        level = LEVEL_W'($urandom_range(0, ledger.top - 1));
      if (ledger.depth > 0 && $urandom_range(0, 5) == 0)
        id = ledger.held_ids[$urandom_range(0, ledger.depth - 1)];
      granted = ($urandom_range(0, 9) != 0);
    end else begin
      cmd     = CMD_RELEASE;
      granted = 1'($urandom_range(0, 1));
      if (ledger.depth > 0) begin
        if ($urandom_range(0, 5) != 0)
          id = ledger.held_ids[ledger.depth - 1];
        else if ($urandom_range(0, 1) != 0)
          id = ledger.held_ids[$urandom_range(0, ledger.depth - 1)];
      end
    end
    send(cmd, id, is_lock, level, granted);
  endtask

  initial begin
    int acq_pct;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    send(CMD_RELEASE, 8'h00, 1'b1, 4'd0, 1'b1);
    send(CMD_ACQUIRE, 8'hff, 1'b0, 4'd15, 1'b1);
    send(CMD_RELEASE, 8'h00, 1'b0, 4'd0, 1'b0);
    send(CMD_ACQUIRE, 8'h00, 1'b1, 4'd0, 1'b1);
    send(CMD_ACQUIRE, 8'hff, 1'b1, 4'd15, 1'b0);
    send(CMD_ACQUIRE, 8'h00, 1'b1, 4'd15, 1'b0);
    send(CMD_ACQUIRE, 8'hff, 1'b1, 4'd15, 1'b1);
    send(CMD_ACQUIRE, 8'h00, 1'b1, 4'd3, 1'b1);
    send(CMD_RELEASE, 8'h00, 1'b1, 4'd15, 1'b1);
    for (int i = 1; i <= DEPTH - 2; i++)
      send(CMD_ACQUIRE, ID_W'(i), 1'b1, 4'd15, 1'b1);
    send(CMD_ACQUIRE, 8'h80, 1'b1, 4'd15, 1'b1);
    send(CMD_RELEASE, ID_W'(DEPTH - 2), 1'b1, 4'd0, 1'b0);
    drain();

    for (int p = 0; p < 15; p++) begin
      case ($urandom_range(0, 2))
        0: acq_pct = 45;
        1: acq_pct = 60;
        default: acq_pct = 85;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (100) send_random(acq_pct);
      if (p % 3 == 2) drain();
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("sync_level_lock_stack: match");
    end else begin
      $display("sync_level_lock_stack: mismatch");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("sync_level_lock_stack: mismatch");
    $finish;
  end

endmodule
